// ----- rtl/swm_pkg.sv -----
// Shared constants and helpers for the sliding window median unit.
// No dependencies; every other file in rtl/ imports this package.
package swm_pkg;

	// Default sizing of the window and of one sample.
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 31;

	// Window size register.
	localparam int                  CFG_BITS  = 7;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd3;

	// Cells per group in the first level of the median select tree.
	localparam int GROUP_SIZE = 8;

	// Number of select tree groups needed to cover a window of the given depth.
	function automatic int n_groups(input int depth);
		return (depth + GROUP_SIZE - 1) / GROUP_SIZE;
	endfunction

endpackage

// ----- rtl/sliding_window_median_unit.sv -----
// Top level of the sliding window median unit: handshakes, window size
// register, pipeline stages and final median select. Uses swm_pkg and swm_cell_row.
//
//   channel   signals                                       direction
//   config    window_size_we, window_size                   in
//   sample    sample_valid, sample_stall, sample            in
//   median    median_valid, median_stall, median            out
//
// One sample beat is taken every cycle while sample_stall is low.
// Stage 1 registers the sample, the cell row updates as it leaves stage 1, stage 2
// holds the group partials and stage 3 is the result register.
// Results appear once window_size - 1 samples are held; a window size write flushes.
// Reset clears the valid bits and sets the window to three samples.
// A stalled result holds; each stage still loads while the one after it moves.
module sliding_window_median_unit import swm_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   window_size_we,
	input  logic [CFG_BITS-1:0]    window_size,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   median_valid,
	input  logic                   median_stall,
	output logic [SAMPLE_BITS-1:0] median
);

	localparam int WB   = $clog2(WINDOW_MAX + 1);
	localparam int NGRP = n_groups(WINDOW_MAX);

	// Effective window: zero acts as one, large values saturate.
	function automatic logic [WB-1:0] win_of(input logic [CFG_BITS-1:0] cfg);
		if (cfg == '0) begin
			return WB'(1);
		end else if (int'(cfg) > WINDOW_MAX) begin
			return WB'(WINDOW_MAX);
		end else begin
			return WB'(cfg);
		end
	endfunction

	logic [WB-1:0]          win_q;
	logic                   vld_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   vld_s2;
	logic [SAMPLE_BITS-1:0] part_s2 [NGRP];
	logic [SAMPLE_BITS-1:0] pick_s2;
	logic                   ovld_q;
	logic [SAMPLE_BITS-1:0] median_q;

	logic                   en1;
	logic                   en2;
	logic                   en3;
	logic                   step;
	logic                   cell_full;
	logic [SAMPLE_BITS-1:0] cell_pick;
	logic [SAMPLE_BITS-1:0] cell_part [NGRP];
	logic [SAMPLE_BITS-1:0] med_or;

	// Stage enables: a stage loads when it is empty or the next one takes its beat.
	assign en3          = !ovld_q || !median_stall;
	assign en2          = !vld_s2 || en3;
	assign en1          = !vld_s1 || en2;
	assign sample_stall = !en1;
	assign step         = vld_s1 && en2;

	// Window size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= win_of(CFG_RESET);
		end else if (window_size_we) begin
			win_q <= win_of(window_size);
		end
	end

	swm_cell_row #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_cell_row (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (window_size_we),
		.step   (step),
		.sample (sample_s1),
		.win    (win_q),
		.full   (cell_full),
		.pick   (cell_pick),
		.part   (cell_part)
	);

	// Stage valid flags; a beat that gives no result ends at stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= sample_valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1 && cell_full;
			end
			if (en3) begin
				ovld_q <= vld_s2;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (en1) begin
			sample_s1 <= sample;
		end
		if (en2) begin
			pick_s2 <= cell_pick;
			for (int g = 0; g < NGRP; g++) begin
				part_s2[g] <= cell_part[g];
			end
		end
		if (en3) begin
			median_q <= med_or;
		end
	end

	// Second level of the select tree: only one term is nonzero.
	always_comb begin
		med_or = pick_s2;
		for (int g = 0; g < NGRP; g++) begin
			med_or = med_or | part_s2[g];
		end
	end

	assign median_valid = ovld_q;
	assign median       = median_q;

	// A new result comes only from a beat waiting in stage 2.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(median_valid) |-> $past(vld_s2))
		else $error("result appeared without a stage 2 beat");

	// Stage 2 fills only from a stage 1 beat that met a full window.
	a_s2_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s2) |-> $past(vld_s1 && cell_full))
		else $error("stage 2 loaded without a full window");

	// A blocked stage 2 beat keeps its median pick.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !en3) |=> (vld_s2 && $stable(pick_s2)))
		else $error("blocked stage 2 beat changed");

endmodule

// ----- rtl/swm_cell_row.sv -----
// Row of sorted window cells: insert, age-based removal and median select masks.
// Depends on swm_pkg for group sizing.
module swm_cell_row import swm_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int WB         = $clog2(WINDOW_MAX + 1),
	localparam int NGRP       = n_groups(WINDOW_MAX)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   flush,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [WB-1:0]          win,
	output logic                   full,
	output logic [SAMPLE_BITS-1:0] pick,
	output logic [SAMPLE_BITS-1:0] part [NGRP]
);

	localparam int AW = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;

	// Cell contents, kept in ascending order from cell 0; valid cells are contiguous.
	logic [SAMPLE_BITS-1:0] val_q [WINDOW_MAX];
	logic [AW-1:0]          age_q [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]  vld_q;

	logic [WINDOW_MAX-1:0]  lt;
	logic [WINDOW_MAX-1:0]  drop;
	logic [WINDOW_MAX-1:0]  rm;
	logic [WINDOW_MAX-1:0]  rvld;
	logic [WINDOW_MAX-1:0]  rlt;
	logic [WINDOW_MAX-1:0]  nvld;
	logic [WINDOW_MAX-1:0]  sel;
	logic [SAMPLE_BITS-1:0] rval [WINDOW_MAX];
	logic [AW-1:0]          rage [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] nval [WINDOW_MAX];
	logic [AW-1:0]          nage [WINDOW_MAX];
	logic [WB-1:0]          rank;
	logic                   keep_s;

	// Compare the new sample against every cell and find the cell that ages out.
	// The window is full when win-1 samples are held, so this beat gives a result.
	always_comb begin
		full = (win == WB'(1));
		for (int k = 0; k < WINDOW_MAX; k++) begin
			if (k + 2 == int'(win)) begin
				full = vld_q[k];
			end
		end
		for (int k = 0; k < WINDOW_MAX; k++) begin
			lt[k]   = vld_q[k] && (val_q[k] <= sample);
			drop[k] = full && vld_q[k] && (int'(age_q[k]) + 2 == int'(win));
		end
	end

	// Every cell at or above the aging-out cell moves down by one.
	assign rm = ~(drop - WINDOW_MAX'(1));

	// Remove the oldest sample from the row.
	always_comb begin
		for (int k = 0; k < WINDOW_MAX; k++) begin
			if (rm[k]) begin
				rval[k] = val_q[(k + 1) % WINDOW_MAX];
				rage[k] = age_q[(k + 1) % WINDOW_MAX];
				rvld[k] = (k < WINDOW_MAX - 1) && vld_q[(k + 1) % WINDOW_MAX];
				rlt[k]  = (k < WINDOW_MAX - 1) && lt[(k + 1) % WINDOW_MAX];
			end else begin
				rval[k] = val_q[k];
				rage[k] = age_q[k];
				rvld[k] = vld_q[k];
				rlt[k]  = lt[k];
			end
		end
	end

	// Insert the new sample after all cells that are less than or equal to it.
	// A window of one keeps nothing, so the sample is not stored.
	assign keep_s = (win != WB'(1));

	always_comb begin
		for (int k = 0; k < WINDOW_MAX; k++) begin
			if (!keep_s || rlt[k]) begin
				nval[k] = rval[k];
				nage[k] = rage[k] + AW'(1);
				nvld[k] = rvld[k];
			end else if ((k == 0) || rlt[(k + WINDOW_MAX - 1) % WINDOW_MAX]) begin
				nval[k] = sample;
				nage[k] = '0;
				nvld[k] = 1'b1;
			end else begin
				nval[k] = rval[(k + WINDOW_MAX - 1) % WINDOW_MAX];
				nage[k] = rage[(k + WINDOW_MAX - 1) % WINDOW_MAX] + AW'(1);
				nvld[k] = rvld[(k + WINDOW_MAX - 1) % WINDOW_MAX];
			end
		end
	end

	// Lower median rank within the held samples plus the new one.
	assign rank = (win - WB'(1)) >> 1;

	// Each cell knows its rank among held samples plus the new one.
	// When no cell holds the median rank, the new sample is the median.
	always_comb begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			sel[i] = vld_q[i] && (lt[i] ? (i == int'(rank)) : (i + 1 == int'(rank)));
		end
		pick = (sel == '0) ? sample : '0;
		for (int g = 0; g < NGRP; g++) begin
			part[g] = '0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				if ((g * GROUP_SIZE + j < WINDOW_MAX) &&
				    sel[(g * GROUP_SIZE + j) % WINDOW_MAX]) begin
					part[g] = part[g] | val_q[(g * GROUP_SIZE + j) % WINDOW_MAX];
				end
			end
		end
	end

	// Valid bits: cleared by reset and by a window size write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (flush) begin
			vld_q <= '0;
		end else if (step) begin
			vld_q <= nvld;
		end
	end

	// Cell payload.
	always_ff @(posedge clk) begin
		if (step) begin
			for (int k = 0; k < WINDOW_MAX; k++) begin
				val_q[k] <= nval[k];
				age_q[k] <= nage[k];
			end
		end
	end

	// Valid cells always form one run starting at cell 0.
	a_vld_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((vld_q & (vld_q + WINDOW_MAX'(1))) == '0))
		else $error("cell valid bits are not contiguous");

	// The row never holds a whole window.
	a_vld_count: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(vld_q) < int'(win)))
		else $error("cell row holds too many samples");

	// A full window with more than one sample ages out exactly one cell.
	a_one_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(step && full && keep_s) |-> $onehot(drop))
		else $error("aging out did not find exactly one cell");

endmodule
